### rtl/hcg_pkg.sv
// Shared types, constants and the sequencer program of the Hermite coefficient generator.
// No dependencies; the channel interfaces and the top level import this package.
package hcg_pkg;

  // Fixed widths of the channel fields.
  localparam int ORDER_W    = 5;
  localparam int OUT_COEF_W = 64;

  // Program counter of the sequencer and the addresses of its steps.
  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] hcg_pc_t;

  localparam hcg_pc_t UC_WAIT  = 3'd0;
  localparam hcg_pc_t UC_CHECK = 3'd1;
  localparam hcg_pc_t UC_SHORT = 3'd2;
  localparam hcg_pc_t UC_ELEM  = 3'd3;
  localparam hcg_pc_t UC_ROW   = 3'd4;
  localparam hcg_pc_t UC_EMIT  = 3'd5;
  localparam hcg_pc_t UC_ERR   = 3'd6;

  // Branch conditions a control word can test.
  typedef enum logic [2:0] {
    COND_IN_FIRE,    // a request transaction is offered
    COND_ORDER_ERR,  // latched order is out of range
    COND_SHORT,      // latched order is zero or one
    COND_COL_MORE,   // more columns left in the current row
    COND_ROW_MORE,   // more rows left before the requested order
    COND_EMIT_MORE,  // coefficients left to send, or output slot still busy
    COND_OUT_BUSY    // output slot cannot take a transaction this cycle
  } hcg_cond_t;

  // One control word: branch test, both successors and the datapath actions.
  typedef struct packed {
    hcg_cond_t cond;
    hcg_pc_t   pc_true;
    hcg_pc_t   pc_false;
    logic      take_in;   // request channel is ready
    logic      init_ctr;  // row counter to two, column counter to zero
    logic      elem;      // compute and store one coefficient of the new row
    logic      row_next;  // advance to the next row
    logic      emit;      // send one coefficient of the finished row
    logic      emit_err;  // send the single out-of-range result
  } hcg_uc_t;

  // The read-only program.
  function automatic hcg_uc_t uc_rom(input hcg_pc_t pc);
    hcg_uc_t w;
    w = '{cond: COND_OUT_BUSY, pc_true: UC_WAIT, pc_false: UC_WAIT,
          take_in: 1'b0, init_ctr: 1'b0, elem: 1'b0, row_next: 1'b0,
          emit: 1'b0, emit_err: 1'b0};
    unique case (pc)
      UC_WAIT: begin
        w.cond = COND_IN_FIRE; w.pc_true = UC_CHECK; w.pc_false = UC_WAIT;
        w.take_in = 1'b1;
      end
      UC_CHECK: begin
        w.cond = COND_ORDER_ERR; w.pc_true = UC_ERR; w.pc_false = UC_SHORT;
        w.init_ctr = 1'b1;
      end
      UC_SHORT: begin
        w.cond = COND_SHORT; w.pc_true = UC_EMIT; w.pc_false = UC_ELEM;
      end
      UC_ELEM: begin
        w.cond = COND_COL_MORE; w.pc_true = UC_ELEM; w.pc_false = UC_ROW;
        w.elem = 1'b1;
      end
      UC_ROW: begin
        w.cond = COND_ROW_MORE; w.pc_true = UC_ELEM; w.pc_false = UC_EMIT;
        w.row_next = 1'b1;
      end
      UC_EMIT: begin
        w.cond = COND_EMIT_MORE; w.pc_true = UC_EMIT; w.pc_false = UC_WAIT;
        w.emit = 1'b1;
      end
      UC_ERR: begin
        w.cond = COND_OUT_BUSY; w.pc_true = UC_ERR; w.pc_false = UC_WAIT;
        w.emit_err = 1'b1;
      end
      default: begin
        w.cond = COND_OUT_BUSY; w.pc_true = UC_WAIT; w.pc_false = UC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/hcg_in_if.sv
// Request channel of the Hermite coefficient generator: valid, ready and the order.
// Depends on hcg_pkg for the field width.
interface hcg_in_if import hcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ORDER_W-1:0] order;

  modport source (output valid, output order, input ready);
  modport sink   (input valid, input order, output ready);
endinterface

### rtl/hcg_out_if.sv
// Result channel of the Hermite coefficient generator: valid, ready and one coefficient.
// Depends on hcg_pkg for the field widths.
interface hcg_out_if import hcg_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [OUT_COEF_W-1:0] coefficient;
  logic        [ORDER_W-1:0]    power;
  logic                         last;
  logic                         order_error;

  modport source (output valid, output coefficient, output power, output last,
                  output order_error, input ready);
  modport sink   (input valid, input coefficient, input power, input last,
                  input order_error, output ready);
endinterface

### rtl/hermite_coefficient_generator_unit.sv
// Hermite coefficient generator: one request of order n returns the n+1 coefficients of H_n.
// Results follow once the rows up to H_n have been built by the single coefficient update unit,
// which handles one row element per cycle; one request is handled at a time.
// An order above MAX_ORDER returns a single result flagged as an order error.
// Reset (rst_n, synchronous, active low) clears the sequencer, counters and output valid.
// Depends on hcg_pkg, hcg_in_if and hcg_out_if.
module hermite_coefficient_generator_unit import hcg_pkg::*; #(
  parameter int MAX_ORDER  = 20,
  parameter int COEF_WIDTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  hcg_in_if.sink   in_chan,
  hcg_out_if.source out_chan
);

  localparam int ROW_DEPTH = MAX_ORDER + 1;
  localparam int IDX_W     = $clog2(ROW_DEPTH);

  typedef logic [COEF_WIDTH-1:0] coef_t;
  typedef logic [ORDER_W-1:0]    idx_t;

  // Rows of the recurrence live in two banks. Row i is written into bank i[0], so
  // the new row overwrites row i-2 in place while row i-1 is read from the other bank.
  // Entries beyond a row's own order are never cleared; reads mask them to zero,
  // and rows zero and one are supplied as constants rather than stored.
  coef_t row_a_r [ROW_DEPTH];
  coef_t row_b_r [ROW_DEPTH];

  // Sequencer and counters.
  hcg_pc_t pc_r, pc_nxt;
  idx_t    order_r, order_nxt;
  idx_t    row_r, row_nxt;   // order of the row being built
  idx_t    col_r, col_nxt;   // column within the row, also the emitted power

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  coef_t         out_coef_r, out_coef_nxt;
  idx_t          out_power_r, out_power_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_err_r, out_err_nxt;

  hcg_uc_t uc;
  logic    cond_hit;
  logic    out_free;
  logic    order_bad;

  idx_t  col_m1;
  idx_t  addr_a, addr_b;
  coef_t rd_a, rd_b;
  coef_t rd_pp, rd_prev, rd_emit;
  coef_t pp_val, prev_val, elem_val;
  logic [ORDER_W:0]            factor;
  logic [COEF_WIDTH+ORDER_W:0] product;

  // Value of column col of row row_idx, given what the bank holds there.
  function automatic coef_t row_value(input idx_t row_idx, input idx_t col, input coef_t stored);
    coef_t v;
    v = '0;
    priority if (row_idx == ORDER_W'(0)) begin
      if (col == ORDER_W'(0)) v = COEF_WIDTH'(1);
    end else if (row_idx == ORDER_W'(1)) begin
      if (col == ORDER_W'(1)) v = COEF_WIDTH'(2);
    end else if (col <= row_idx) begin
      v = stored;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  assign uc        = uc_rom(pc_r);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign order_bad = order_r > ORDER_W'(MAX_ORDER);

  // Branch condition of the current control word.
  always_comb begin
    unique case (uc.cond)
      COND_IN_FIRE:   cond_hit = in_chan.valid;
      COND_ORDER_ERR: cond_hit = order_bad;
      COND_SHORT:     cond_hit = order_r < ORDER_W'(2);
      COND_COL_MORE:  cond_hit = col_r != row_r;
      COND_ROW_MORE:  cond_hit = row_r != order_r;
      COND_EMIT_MORE: cond_hit = !(out_free && (col_r == order_r));
      COND_OUT_BUSY:  cond_hit = !out_free;
      default:        cond_hit = 1'b0;
    endcase
  end

  assign pc_nxt = cond_hit ? uc.pc_true : uc.pc_false;

  // Bank reads: while a row is built, the bank holding row i-1 is read one column
  // to the left; otherwise both banks are read at the current column.
  assign col_m1 = (col_r == ORDER_W'(0)) ? ORDER_W'(0) : col_r - ORDER_W'(1);
  assign addr_a = (uc.elem && row_r[0])  ? col_m1 : col_r;
  assign addr_b = (uc.elem && !row_r[0]) ? col_m1 : col_r;
  assign rd_a   = row_a_r[addr_a[IDX_W-1:0]];
  assign rd_b   = row_b_r[addr_b[IDX_W-1:0]];

  assign rd_pp   = row_r[0]   ? rd_b : rd_a;
  assign rd_prev = row_r[0]   ? rd_a : rd_b;
  assign rd_emit = order_r[0] ? rd_b : rd_a;

  // One element of H_i: 2 * H_{i-1}[j-1] - 2(i-1) * H_{i-2}[j], modulo 2^COEF_WIDTH.
  assign pp_val   = row_value(row_r - ORDER_W'(2), col_r, rd_pp);
  assign prev_val = (col_r == ORDER_W'(0)) ? '0
                  : row_value(row_r - ORDER_W'(1), col_m1, rd_prev);
  assign factor   = {row_r - ORDER_W'(1), 1'b0};
  assign product  = factor * pp_val;
  assign elem_val = (prev_val << 1) - product[COEF_WIDTH-1:0];

  // Counter updates.
  always_comb begin
    order_nxt = order_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    if (uc.take_in && in_chan.valid) begin
      order_nxt = in_chan.order;
    end
    if (uc.init_ctr) begin
      row_nxt = ORDER_W'(2);
      col_nxt = '0;
    end
    if (uc.elem && (col_r != row_r)) begin
      col_nxt = col_r + ORDER_W'(1);
    end
    if (uc.row_next) begin
      row_nxt = row_r + ORDER_W'(1);
      col_nxt = '0;
    end
    if (uc.emit && out_free && (col_r != order_r)) begin
      col_nxt = col_r + ORDER_W'(1);
    end
  end

  // Output register: a new result is loaded whenever the slot is empty or being drained.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_coef_nxt  = out_coef_r;
    out_power_nxt = out_power_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (uc.emit && out_free) begin
      out_valid_nxt = 1'b1;
      out_coef_nxt  = row_value(order_r, col_r, rd_emit);
      out_power_nxt = col_r;
      out_last_nxt  = col_r == order_r;
      out_err_nxt   = 1'b0;
    end else if (uc.emit_err && out_free) begin
      out_valid_nxt = 1'b1;
      out_coef_nxt  = '0;
      out_power_nxt = '0;
      out_last_nxt  = 1'b1;
      out_err_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= UC_WAIT;
      order_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      order_r     <= order_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers and row banks carry no reset.
  always_ff @(posedge clk) begin
    out_coef_r  <= out_coef_nxt;
    out_power_r <= out_power_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
    if (uc.elem) begin
      if (row_r[0]) begin
        row_b_r[col_r[IDX_W-1:0]] <= elem_val;
      end else begin
        row_a_r[col_r[IDX_W-1:0]] <= elem_val;
      end
    end
  end

  // Coefficients are sign-extended from COEF_WIDTH to the channel width.
  assign in_chan.ready        = uc.take_in;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.coefficient = OUT_COEF_W'($signed(out_coef_r));
  assign out_chan.power       = out_power_r;
  assign out_chan.last        = out_last_r;
  assign out_chan.order_error = out_err_r;

endmodule

### bench/hcg_tb_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Hermite coefficient generator: watches request and result transactions,
// predicts the coefficients of H_n and compares every result field by field.
// Depends on hcg_pkg, hcg_in_if and hcg_out_if.
module hcg_tb_checker import hcg_pkg::*; #(
  parameter int MAX_ORDER  = 20,
  parameter int COEF_WIDTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  hcg_in_if    in_mon,
  hcg_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [OUT_COEF_W-1:0] coefficient;
    logic [ORDER_W-1:0]    power;
    logic                  last;
    logic                  order_error;
  } hcg_coef_t;

  hcg_coef_t             hermite_coef_queue[$];
  logic [OUT_COEF_W-1:0] newer_row [MAX_ORDER+1];
  logic [OUT_COEF_W-1:0] older_row [MAX_ORDER+1];
  int                    mismatch_total = 0;
  int                    outstanding = 0;

  assign fail_count = mismatch_total;
  assign pending    = outstanding;

  // Keep COEF_WIDTH bits and sign-extend them to the full result width.
  function automatic logic [OUT_COEF_W-1:0] coef_trim(input logic [OUT_COEF_W-1:0] v);
    return $signed(v << (OUT_COEF_W - COEF_WIDTH)) >>> (OUT_COEF_W - COEF_WIDTH);
  endfunction

  function automatic void queue_coef(input logic [OUT_COEF_W-1:0] coef,
                                     input logic [ORDER_W-1:0] pw,
                                     input logic fin, input logic err);
    hcg_coef_t c;
    c.coefficient = coef_trim(coef);
    c.power       = pw;
    c.last        = fin;
    c.order_error = err;
    hermite_coef_queue.push_back(c);
  endfunction

  // Runs H_i = 2x*H_{i-1} - 2(i-1)*H_{i-2} from H_0 = 1, H_1 = 2x.
  task automatic predict_hermite_coefs(input logic [ORDER_W-1:0] ord);
    logic [OUT_COEF_W-1:0] next_row [MAX_ORDER+1];
    logic [OUT_COEF_W-1:0] factor;
    logic [OUT_COEF_W-1:0] up;
    int                    n;
    n = int'(ord);
    for (int k = 0; k <= MAX_ORDER; k++) begin
      newer_row[k] = '0;
      older_row[k] = '0;
    end
    if (n > MAX_ORDER) begin
      queue_coef('0, '0, 1'b1, 1'b1);
    end else if (n == 0) begin
      queue_coef(64'd1, '0, 1'b1, 1'b0);
    end else begin
      older_row[0] = 64'd1;
      newer_row[1] = 64'd2;
      for (int i = 2; i <= n; i++) begin
        factor = OUT_COEF_W'(2 * (i - 1));
        for (int j = 0; j <= MAX_ORDER; j++) begin
          if (j <= i) begin
            up = (j > 0) ? (newer_row[j-1] << 1) : '0;
            next_row[j] = coef_trim(up - factor * older_row[j]);
          end else begin
            next_row[j] = '0;
          end
        end
        older_row = newer_row;
        newer_row = next_row;
      end
      for (int j = 0; j <= n; j++)
        queue_coef(newer_row[j], j[ORDER_W-1:0], j == n, 1'b0);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [OUT_COEF_W-1:0] got,
                                 input logic [OUT_COEF_W-1:0] want, input int pw);
    $display("[%0t] %s mismatch at power %0d: got %0d, expected %0d",
             $time, field, pw, $signed(got), $signed(want));
    mismatch_total++;
  endtask

  always @(posedge clk) begin
    hcg_coef_t want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (hermite_coef_queue.size() == 0) begin
          report_mismatch("unexpected result", out_mon.coefficient, '0,
                          int'(out_mon.power));
        end else begin
          want = hermite_coef_queue.pop_front();
          if (out_mon.coefficient !== want.coefficient)
            report_mismatch("coefficient", out_mon.coefficient, want.coefficient,
                            int'(want.power));
          if (out_mon.power !== want.power)
            report_mismatch("power", OUT_COEF_W'(out_mon.power), OUT_COEF_W'(want.power),
                            int'(want.power));
          if (out_mon.last !== want.last)
            report_mismatch("last", OUT_COEF_W'(out_mon.last), OUT_COEF_W'(want.last),
                            int'(want.power));
          if (out_mon.order_error !== want.order_error)
            report_mismatch("order_error", OUT_COEF_W'(out_mon.order_error),
                            OUT_COEF_W'(want.order_error), int'(want.power));
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_hermite_coefs(in_mon.order);
      outstanding = hermite_coef_queue.size();
    end
  end

endmodule

### bench/hermite_coefficient_generator_unit_tb.sv
`timescale 1ns / 100ps
// Top of the Hermite coefficient generator testbench: clock, reset, request stimulus and
// result back-pressure. Depends on hcg_pkg, both channel interfaces, the block and hcg_tb_checker.
module hermite_coefficient_generator_unit_tb;
  import hcg_pkg::*;

  localparam int MAX_ORDER        = 20;
  localparam int COEF_WIDTH       = 64;
  // Even with every request at the largest order and heavy result stalling, the run stays
  // far below this bound.
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int HOLD_CYCLES      = 400;
  localparam int RANDOM_PER_PHASE = 53;
  // Once a request's last result is loaded into the output slot, the block returns to its wait state.
  localparam int DRAIN_CYCLES     = 40;

  logic clk = 1'b0;
  logic rst_n;

  hcg_in_if  in_chan ();
  hcg_out_if out_chan ();

  int   fail_count;
  int   pending;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   cycle_count = 0;
  // The receiver owns its hold-off counter; the stimulus only flips the request toggle.
  int   hold_left   = 0;
  logic hold_tgl    = 1'b0;
  logic hold_seen   = 1'b0;

  // Orders chosen to hit the direct cases (0 and 1), the first recurrence steps, the top
  // legal order and the out-of-range orders on both ends of that range.
  logic [ORDER_W-1:0] directed_orders [] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd20,
                                             5'd21, 5'd31, 5'd30, 5'd16, 5'd15, 5'd8,
                                             5'd0, 5'd19, 5'd1, 5'd20, 5'd11};

  hermite_coefficient_generator_unit #(
    .MAX_ORDER (MAX_ORDER),
    .COEF_WIDTH(COEF_WIDTH)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  hcg_tb_checker #(
    .MAX_ORDER (MAX_ORDER),
    .COEF_WIDTH(COEF_WIDTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a run that never drains its expected results ends here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result receiver. A flip of hold_tgl starts a long hold-off during which ready stays low,
  // so the block cannot finish its request and stops taking new ones. Otherwise ready drops
  // at random according to the stall percentage of the current phase.
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one request and returns at the edge where the transaction is taken. Valid is left
  // high so that back-to-back requests never lower and raise it within one time step; idle
  // gaps, when the phase calls for them, put random junk on the order bus while valid is low.
  task automatic send_order(input logic [ORDER_W-1:0] ord);
    if ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      in_chan.order <= ORDER_W'($urandom());
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_chan.valid <= 1'b1;
    in_chan.order <= ord;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Stops offering requests and waits for every predicted coefficient to come back. The first
  // edge lets the checker register the last accepted request before pending is looked at.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // One block of random requests. Most orders are legal, with extra weight on the largest
  // one; about a tenth lie above the maximum and must come back flagged as errors.
  task automatic random_phase(input int idle, input int stall, input bit with_hold);
    logic [ORDER_W-1:0] ord;
    int                 r;
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
      r = $urandom_range(99);
      if (r < 10)
        ord = ORDER_W'($urandom_range(31, MAX_ORDER + 1));
      else if (r < 20)
        ord = ORDER_W'(MAX_ORDER);
      else
        ord = ORDER_W'($urandom_range(MAX_ORDER));
      // Start the long hold-off a few requests in, while the sender keeps offering.
      if (with_hold && k == 4)
        hold_tgl <= ~hold_tgl;
      send_order(ord);
    end
    drain_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.order  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests with no idling on either side. After the seventh request, the sender pauses
    // until every expected coefficient has been delivered.
    foreach (directed_orders[k]) begin
      send_order(directed_orders[k]);
      if (k == 6)
        drain_results();
    end
    drain_results();

    // Random phases: no idling with a long receiver hold-off, sender idling, receiver
    // stalling, then both.
    random_phase(0, 0, 1'b1);
    random_phase(50, 0, 1'b0);
    random_phase(0, 50, 1'b0);
    random_phase(34, 34, 1'b0);

    // Give any stray result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
